/* hdl/depth_to_point_backprojection_core_defines.svh */
// Assertion macros shared by the front end and queue RTL files.
`ifndef DEPTH_TO_POINT_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define DTPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DTPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dtpb_pkg.sv */
package dtpb_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CNT_W   = 12;
    localparam int DIM_W   = 13;
    localparam int MAG_W   = 13;
    localparam int DEPTH_W = 24;
    localparam int SCALE_W = 25;
    localparam int COORD_W = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0]   LAST_IDX       = CNT_W'(MAX_DIM - 1);
    localparam logic [SCALE_W-1:0] INV_FOCAL_INIT = 25'd16777216;
    localparam logic [DIM_W-1:0]   WIDTH_INIT     = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_INIT    = 13'd480;

    localparam logic [1:0] REG_INV_FOCAL_X  = 2'd0;
    localparam logic [1:0] REG_INV_FOCAL_Y  = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic               frame_end;
    } item_t;

endpackage

/* hdl/dtpb_front.sv */
`include "depth_to_point_backprojection_core_defines.svh"

module dtpb_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dtpb_pkg::DIM_W-1:0]   frame_width,
    input  logic [dtpb_pkg::DIM_W-1:0]   frame_height,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dtpb_pkg::DEPTH_W-1:0] in_depth,
    output logic                         item_valid,
    input  logic                         item_ready,
    output dtpb_pkg::item_t              item
);

    logic [dtpb_pkg::CNT_W-1:0] col_reg, col_next;
    logic [dtpb_pkg::CNT_W-1:0] row_reg, row_next;
    logic                       accept;
    logic                       last_col;
    logic                       last_row;
    logic [13:0]                dx, dy, dx_neg, dy_neg;

    assign in_ready   = item_ready;
    assign item_valid = in_valid;
    assign accept     = in_valid && item_ready;

    assign last_col = ({1'b0, col_reg} + 13'd1 >= frame_width) || (col_reg == dtpb_pkg::LAST_IDX);
    assign last_row = ({1'b0, row_reg} + 13'd1 >= frame_height) || (row_reg == dtpb_pkg::LAST_IDX);

    // Twice the offset from the image center; the halving is folded into the back end shift.
    assign dx     = {1'b0, col_reg, 1'b0} - {1'b0, frame_width};
    assign dy     = {1'b0, row_reg, 1'b0} - {1'b0, frame_height};
    assign dx_neg = 14'd0 - dx;
    assign dy_neg = 14'd0 - dy;

    always_comb
    begin
        item.neg_x     = dx[13];
        item.mag_x     = dx[13] ? dx_neg[12:0] : dx[12:0];
        item.neg_y     = dy[13];
        item.mag_y     = dy[13] ? dy_neg[12:0] : dy[12:0];
        item.depth     = in_depth;
        item.frame_end = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `DTPB_ASSERT_NEXT(a_frame_end_wraps, accept && item.frame_end,
        col_reg == '0 && row_reg == '0, "Counters did not return to zero after frame end")
    `DTPB_ASSERT_NEXT(a_col_steps, accept && !last_col,
        col_reg == $past(col_reg) + 1'b1 && row_reg == $past(row_reg),
        "Column counter did not advance by one")
    `DTPB_ASSERT_NEXT(a_hold_idle, !accept, $stable(col_reg) && $stable(row_reg),
        "Counters moved without a transfer")

endmodule

/* hdl/dtpb_queue.sv */
`include "depth_to_point_backprojection_core_defines.svh"

module dtpb_queue
#(
    parameter int DEPTH = dtpb_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dtpb_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output dtpb_pkg::item_t out_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dtpb_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_ready && out_valid;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DTPB_ASSERT_SAME(a_no_pop_empty, pop, count_reg != '0, "Queue popped while empty")
    `DTPB_ASSERT_SAME(a_no_push_full, push, count_reg != CNT_W'(DEPTH),
        "Queue pushed while full")
    `DTPB_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "Queue fill count did not grow on push")

endmodule

/* hdl/dtpb_back.sv */
module dtpb_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dtpb_pkg::SCALE_W-1:0]  inv_focal_x,
    input  logic [dtpb_pkg::SCALE_W-1:0]  inv_focal_y,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dtpb_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dtpb_pkg::COORD_W-1:0]  point_x,
    output logic [dtpb_pkg::COORD_W-1:0]  point_y,
    output logic [dtpb_pkg::DEPTH_W-1:0]  point_z,
    output logic                          frame_end
);

    localparam int SHIFT = dtpb_pkg::SCALE_FRAC_BITS + 1;

    // Rounds |offset| * depth * scale / 2^(SCALE_FRAC_BITS+1), applies the sign and saturates.
    function automatic logic [31:0] finish_axis(input logic [43:0] lo, input logic [42:0] hi,
                                                input logic neg);
        logic [61:0] sum;
        logic [36:0] mag;
        logic [31:0] res;
        sum = {hi, 19'd0} + {18'd0, lo} + (62'd1 << (SHIFT - 1));
        mag = sum[61:SHIFT];
        if (neg)
        begin
            res = (mag > 37'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        else
        begin
            res = (mag > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction

    logic        adv;
    logic        s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [36:0] s1_px_reg, s1_py_reg;
    logic        s1_neg_x_reg, s1_neg_y_reg, s2_neg_x_reg, s2_neg_y_reg;
    logic [23:0] s1_depth_reg, s2_depth_reg;
    logic        s1_end_reg, s2_end_reg;
    logic [43:0] s2_lo_x_reg, s2_lo_y_reg;
    logic [42:0] s2_hi_x_reg, s2_hi_y_reg;
    logic [31:0] point_x_reg, point_y_reg;
    logic [23:0] point_z_reg;
    logic        frame_end_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;
    assign frame_end = frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg     <= in_item.mag_x * in_item.depth;
            s1_py_reg     <= in_item.mag_y * in_item.depth;
            s1_neg_x_reg  <= in_item.neg_x;
            s1_neg_y_reg  <= in_item.neg_y;
            s1_depth_reg  <= in_item.depth;
            s1_end_reg    <= in_item.frame_end;

            s2_lo_x_reg   <= s1_px_reg[18:0] * inv_focal_x;
            s2_hi_x_reg   <= s1_px_reg[36:19] * inv_focal_x;
            s2_lo_y_reg   <= s1_py_reg[18:0] * inv_focal_y;
            s2_hi_y_reg   <= s1_py_reg[36:19] * inv_focal_y;
            s2_neg_x_reg  <= s1_neg_x_reg;
            s2_neg_y_reg  <= s1_neg_y_reg;
            s2_depth_reg  <= s1_depth_reg;
            s2_end_reg    <= s1_end_reg;

            point_x_reg   <= finish_axis(s2_lo_x_reg, s2_hi_x_reg, s2_neg_x_reg);
            point_y_reg   <= finish_axis(s2_lo_y_reg, s2_hi_y_reg, s2_neg_y_reg);
            point_z_reg   <= s2_depth_reg;
            frame_end_reg <= s2_end_reg;
        end
    end

endmodule

/* hdl/depth_to_point_backprojection_core.sv */
// Path: a result is offered once its input transfer has passed the queue stage and the
// two multiply stages ahead of the output register; an output stall can hold it on the way.
// Throughput: one pixel per cycle; a stall at the output holds the multiply pipeline,
// and the input stalls once the queue is full.
// Reset: row and column counters clear to zero, registers return to their defaults
// (unit focal reciprocals, 640 by 480), and the queue and pipeline empty at once.
module depth_to_point_backprojection_core
#(
    parameter int QUEUE_DEPTH = dtpb_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtpb_pkg::ADDR_W-1:0]   paddr,
    input  logic [dtpb_pkg::DATA_W-1:0]   pwdata,
    output logic [dtpb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // depth
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [87:0]                   m_tdata,   // point_x, point_y, point_z
    output logic                          m_tlast
);

    logic [dtpb_pkg::SCALE_W-1:0] inv_focal_x_reg, inv_focal_y_reg;
    logic [dtpb_pkg::DIM_W-1:0]   frame_width_reg, frame_height_reg;
    logic                         wr_en;
    logic                         fq_valid, fq_ready, qb_valid, qb_ready;
    dtpb_pkg::item_t              fq_item, qb_item;
    logic [31:0]                  point_x, point_y;
    logic [23:0]                  point_z;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg  <= dtpb_pkg::INV_FOCAL_INIT;
            inv_focal_y_reg  <= dtpb_pkg::INV_FOCAL_INIT;
            frame_width_reg  <= dtpb_pkg::WIDTH_INIT;
            frame_height_reg <= dtpb_pkg::HEIGHT_INIT;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                dtpb_pkg::REG_INV_FOCAL_X:  inv_focal_x_reg  <= pwdata[24:0];
                dtpb_pkg::REG_INV_FOCAL_Y:  inv_focal_y_reg  <= pwdata[24:0];
                dtpb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[12:0];
                dtpb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            dtpb_pkg::REG_INV_FOCAL_X:  prdata = {7'd0, inv_focal_x_reg};
            dtpb_pkg::REG_INV_FOCAL_Y:  prdata = {7'd0, inv_focal_y_reg};
            dtpb_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_reg};
            dtpb_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_reg};
            default:                    prdata = '0;
        endcase
    end

    dtpb_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_depth     (s_tdata),
        .item_valid   (fq_valid),
        .item_ready   (fq_ready),
        .item         (fq_item)
    );

    dtpb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    dtpb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .inv_focal_x (inv_focal_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .frame_end   (m_tlast)
    );

    assign m_tdata = {point_z, point_y, point_x};

endmodule
